// ----- rtl/core/radix_seven_segment_formatter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment formatter
// Shared property templates for the port checkers of this block.
// ----------------------------------------------------------------------------
`ifndef RADIX_SEVEN_SEGMENT_FORMATTER_ASSERT_SVH
`define RADIX_SEVEN_SEGMENT_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define RSSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rssf check failed");

// Next-cycle implication, disabled while reset is low
`define RSSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rssf check failed");

`endif

// ----- rtl/core/rssf_pkg.sv -----
// ----------------------------------------------------------------------------
// rssf_pkg
// Types, constants and segment table of the radix seven-segment formatter.
// ----------------------------------------------------------------------------
package rssf_pkg;

    localparam int VALUE_W     = 16;
    localparam int RADIX_W     = 5;
    localparam int REM_W       = RADIX_W - 1;
    localparam int CODE_W      = 8;
    localparam int POS_W       = 3;
    localparam int OUT_TDATA_W = 16;

    typedef logic [VALUE_W-1:0] t_mag;
    typedef logic [RADIX_W-1:0] t_radix;
    typedef logic [REM_W-1:0]   t_rem;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [POS_W-1:0]   t_pos;

    // Item traveling through the digit pipeline
    typedef struct packed {
        t_mag mag;
        logic neg;
    } t_item;

    localparam t_radix RADIX_DEC  = 5'd10;
    localparam t_radix RADIX_MAX  = 5'd16;
    localparam t_code  CODE_MINUS = 8'h40;
    localparam t_code  CODE_BLANK = 8'h00;

    // Segment pattern of one digit
    function automatic t_code seg_code(input t_rem digit);
        t_code code;
        case (digit)
            4'h0:    code = 8'hbd;
            4'h1:    code = 8'h09;
            4'h2:    code = 8'h75;
            4'h3:    code = 8'h6d;
            4'h4:    code = 8'hc9;
            4'h5:    code = 8'hec;
            4'h6:    code = 8'hfc;
            4'h7:    code = 8'h0d;
            4'h8:    code = 8'hfd;
            4'h9:    code = 8'hed;
            4'ha:    code = 8'hdd;
            4'hb:    code = 8'hf8;
            4'hc:    code = 8'hb4;
            4'hd:    code = 8'h79;
            4'he:    code = 8'hf4;
            default: code = 8'hd4;
        endcase
        return code;
    endfunction

    // Map the raw register value onto a usable base: zero is decimal, clamp at 16
    function automatic t_radix eff_radix(input t_radix raw);
        t_radix r;
        if (raw == '0) begin
            r = RADIX_DEC;
        end else if (raw > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = raw;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/rssf_digit.sv -----
// ----------------------------------------------------------------------------
// rssf_digit
// One digit of the conversion: long division of the magnitude by the radix
// over two register stages, then the segment code of the remainder is
// shifted into the code vector.
// ----------------------------------------------------------------------------
module rssf_digit #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  rssf_pkg::t_radix                            i_radix,
    input  logic                                        i_blank_en,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  rssf_pkg::t_item                             i_item,
    input  logic [DIGIT_COUNT*rssf_pkg::CODE_W-1:0]     i_codes,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output rssf_pkg::t_item                             o_item,
    output logic [DIGIT_COUNT*rssf_pkg::CODE_W-1:0]     o_codes
);
    import rssf_pkg::*;

    localparam int CODES_W = DIGIT_COUNT * CODE_W;
    localparam int HALF_W  = VALUE_W / 2;

    // Stage 1 registers: upper quotient bits and running remainder
    logic               r_v1;
    logic [HALF_W-1:0]  r_q_hi;
    logic [HALF_W-1:0]  r_lo;
    t_rem               r_rem1;
    logic               r_neg1;
    logic               r_blank1;
    logic [CODES_W-1:0] r_codes1;

    // Stage 2 registers
    logic               r_v2;
    t_item              r_item2;
    logic [CODES_W-1:0] r_codes2;

    logic                      ready1;
    logic                      ready2;
    logic [HALF_W-1:0]         n_q_hi;
    t_rem                      n_rem1;
    logic [HALF_W-1:0]         q_lo;
    t_rem                      rem2;
    t_radix                    trial_a;
    t_radix                    trial_b;
    t_code                     code;
    logic [CODES_W+CODE_W-1:0] codes_ext;

    assign ready2  = !r_v2 || i_ready;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;

    // Divide the upper half, one quotient bit per step
    always_comb begin
        n_rem1  = '0;
        n_q_hi  = '0;
        trial_a = '0;
        for (int b = HALF_W - 1; b >= 0; b--) begin
            trial_a = {n_rem1, i_item.mag[HALF_W+b]};
            if (trial_a >= i_radix) begin
                n_q_hi[b] = 1'b1;
                trial_a   = trial_a - i_radix;
            end
            n_rem1 = trial_a[REM_W-1:0];
        end
    end

    // Finish the lower half and form the digit code
    always_comb begin
        rem2    = r_rem1;
        q_lo    = '0;
        trial_b = '0;
        for (int b = HALF_W - 1; b >= 0; b--) begin
            trial_b = {rem2, r_lo[b]};
            if (trial_b >= i_radix) begin
                q_lo[b] = 1'b1;
                trial_b = trial_b - i_radix;
            end
            rem2 = trial_b[REM_W-1:0];
        end
        code      = r_blank1 ? CODE_BLANK : seg_code(rem2);
        codes_ext = {code, r_codes1};
    end

    // Control: valid bits advance with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload: load each stage when it can move
    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r_q_hi   <= n_q_hi;
            r_rem1   <= n_rem1;
            r_lo     <= i_item.mag[HALF_W-1:0];
            r_neg1   <= i_item.neg;
            r_blank1 <= i_blank_en && (i_item.mag == '0) && (i_radix == RADIX_DEC);
            r_codes1 <= i_codes;
        end
        if (ready2 && r_v1) begin
            r_item2.mag <= {r_q_hi, q_lo};
            r_item2.neg <= r_neg1;
            r_codes2    <= codes_ext[CODES_W+CODE_W-1:CODE_W];
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item2;
    assign o_codes = r_codes2;

endmodule

// ----- rtl/core/rssf_serializer.sv -----
// ----------------------------------------------------------------------------
// rssf_serializer
// Turns one converted item into its display writes, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module rssf_serializer #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [DIGIT_COUNT*rssf_pkg::CODE_W-1:0] i_codes,
    input  logic                                    i_neg,
    output logic                                    o_tvalid,
    input  logic                                    i_tready,
    output rssf_pkg::t_pos                          o_pos,
    output rssf_pkg::t_code                         o_code,
    output logic                                    o_last
);
    import rssf_pkg::*;

    localparam int CODES_W = DIGIT_COUNT * CODE_W;
    localparam int IDX_W   = $clog2(DIGIT_COUNT + 1);
    localparam int SUM_W   = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [CODES_W-1:0] r_codes;
    logic               r_neg;
    logic               r_out_valid;
    t_pos               r_pos;
    t_code              r_code;
    logic               r_last;

    logic             out_load;
    logic             emit;
    logic             at_minus;
    logic [SUM_W-1:0] pos_sum;
    t_pos             n_pos;
    t_code            n_code;
    logic             n_last;
    logic             accept;

    // Next write of the current item
    always_comb begin
        out_load = !r_out_valid || i_tready;
        emit     = r_busy && out_load;
        at_minus = (r_idx == IDX_W'(DIGIT_COUNT));
        pos_sum  = SUM_W'(r_idx) + (at_minus ? SUM_W'(0) : SUM_W'(1));
        n_pos    = pos_sum[POS_W-1:0];
        n_code   = at_minus ? CODE_MINUS : r_codes[CODE_W-1:0];
        n_last   = at_minus || (!r_neg && (r_idx == IDX_W'(DIGIT_COUNT - 1)));
        o_ready  = !r_busy || (emit && n_last);
        accept   = i_valid && o_ready;
    end

    // Control: busy flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= emit;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (emit && n_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Payload: load the output write
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pos  <= n_pos;
            r_code <= n_code;
            r_last <= n_last;
        end
    end

    // Advance through the digits, take a new item over the old one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_codes <= i_codes;
            r_neg   <= i_neg;
            r_idx   <= '0;
        end else if (emit) begin
            r_codes <= r_codes >> CODE_W;
            r_idx   <= r_idx + IDX_W'(1);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_pos    = r_pos;
    assign o_code   = r_code;
    assign o_last   = r_last;

endmodule

// ----- rtl/core/radix_seven_segment_formatter.sv -----
// ----------------------------------------------------------------------------
// radix_seven_segment_formatter
// Formats a 16-bit value into seven-segment display-driver writes.
// ----------------------------------------------------------------------------
// Each accepted value gives DIGIT_COUNT writes (positions 1 upward, least
// significant digit first) and, for a negative value in signed mode, one
// more write with the minus sign at the top position. The output stage
// gives one write per cycle while m_axis_tready does not stall it, and the
// serializer takes the next item as it issues the last write of the
// current one. From input transaction to first write a value passes one
// input register, two division stages per digit, the serializer's item
// register and the output register. Write the radix only while the block
// is idle; zero selects decimal and values above 16 act as 16.
module radix_seven_segment_formatter #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,   // radix
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] value
    input  logic [0:0]  s_axis_tuser,    // [0] signed_mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [2:0] digit_position, [10:3] segment_code, pad
    output logic        m_axis_tlast
);
    import rssf_pkg::*;

    localparam int CODES_W = DIGIT_COUNT * CODE_W;

    t_radix r_radix;
    logic   r_v0;
    t_item  r_item0;
    logic   ready0;
    logic   in_neg;
    t_mag   in_mag;

    logic               stg_valid [DIGIT_COUNT+1];
    logic               stg_ready [DIGIT_COUNT+1];
    t_item              stg_item  [DIGIT_COUNT+1];
    logic [CODES_W-1:0] stg_codes [DIGIT_COUNT+1];

    t_pos  out_pos;
    t_code out_code;

    // Radix register, stored already mapped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_DEC;
        end else if (i_cfg_wr_en) begin
            r_radix <= eff_radix(i_cfg_wr_data);
        end
    end

    // Input stage: sign and magnitude
    assign in_neg        = s_axis_tuser[0] && s_axis_tdata[VALUE_W-1];
    assign in_mag        = in_neg ? (~s_axis_tdata + t_mag'(1)) : s_axis_tdata;
    assign ready0        = !r_v0 || stg_ready[0];
    assign s_axis_tready = ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (ready0) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready0 && s_axis_tvalid) begin
            r_item0.mag <= in_mag;
            r_item0.neg <= in_neg;
        end
    end

    assign stg_valid[0] = r_v0;
    assign stg_item[0]  = r_item0;
    assign stg_codes[0] = '0;

    // Digit chain, least significant digit first
    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
        rssf_digit #(
            .DIGIT_COUNT (DIGIT_COUNT)
        ) u_digit (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_radix    (r_radix),
            .i_blank_en (g != 0),
            .i_valid    (stg_valid[g]),
            .o_ready    (stg_ready[g]),
            .i_item     (stg_item[g]),
            .i_codes    (stg_codes[g]),
            .o_valid    (stg_valid[g+1]),
            .i_ready    (stg_ready[g+1]),
            .o_item     (stg_item[g+1]),
            .o_codes    (stg_codes[g+1])
        );
    end

    // Output writes
    rssf_serializer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stg_valid[DIGIT_COUNT]),
        .o_ready  (stg_ready[DIGIT_COUNT]),
        .i_codes  (stg_codes[DIGIT_COUNT]),
        .i_neg    (stg_item[DIGIT_COUNT].neg),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_pos    (out_pos),
        .o_code   (out_code),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - CODE_W - POS_W){1'b0}}, out_code, out_pos};

endmodule

// ----- rtl/core/rssf_checker.sv -----
// ----------------------------------------------------------------------------
// rssf_checker
// Port-level checks of the formatter's output writes, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix_seven_segment_formatter_assert.svh"

module rssf_checker #(
    parameter int DIGIT_COUNT = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wr_en,
    input logic [4:0]  i_cfg_wr_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import rssf_pkg::*;

    localparam t_pos TOP_POS = POS_W'(DIGIT_COUNT);

    // Hold a stalled write
    `RSSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // The minus sign ends the item and sits at the top position
    `RSSF_ASSERT_IMPLY(a_minus_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[10:3] == CODE_MINUS), m_axis_tlast && (m_axis_tdata[2:0] == TOP_POS))

    // A final digit write is always at the top position
    `RSSF_ASSERT_IMPLY(a_last_pos, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[2:0] == TOP_POS)

endmodule

bind radix_seven_segment_formatter rssf_checker #(
    .DIGIT_COUNT (DIGIT_COUNT)
) u_rssf_checker (.*);
